/* sv/gmca_pkg.sv */
// Shared codes, types and constants of the grid map cell store.
package gmca_pkg;

  localparam int unsigned SIZE_W = 9;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // request kinds
  localparam logic [2:0] KIND_READ_COORD  = 3'd0;
  localparam logic [2:0] KIND_WRITE_COORD = 3'd1;
  localparam logic [2:0] KIND_CMP_COORD   = 3'd2;
  localparam logic [2:0] KIND_READ_WORLD  = 3'd3;
  localparam logic [2:0] KIND_WRITE_WORLD = 3'd4;
  localparam logic [2:0] KIND_CMP_WORLD   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RES_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RES_Y = 3'd5;

  localparam logic [SIZE_W-1:0] SIZE_RESET    = 9'd256;
  localparam logic [31:0]       INV_RES_RESET = 32'h0001_0000;

  localparam logic signed [IDX_W-1:0] IDX_MAX = 16'sh7FFF;
  localparam logic signed [IDX_W-1:0] IDX_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_CMP
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SUB,
    S_MUL,
    S_RND,
    S_ADDR,
    S_MEM,
    S_OUT
  } state_t;

  // stage enables of the world-to-cell converter
  typedef struct packed {
    logic sub;
    logic mul;
  } conv_en_t;

endpackage

/* sv/gmca_world_conv.sv */
// World position to cell index converter for one axis: subtract, multiply, round, saturate.
module gmca_world_conv import gmca_pkg::*; (
  input  logic                    clk,
  input  conv_en_t                en,
  input  logic signed [31:0]      pos,
  input  logic signed [31:0]      org,
  input  logic [31:0]             inv,
  output logic signed [IDX_W-1:0] idx
);

  logic signed [32:0] diff;
  logic               neg_q;
  logic [31:0]        mag_q;
  logic               neg_mul_q;
  logic [63:0]        prod_q;
  logic [64:0]        sum;
  logic [32:0]        rounded;

  assign diff = 33'(pos) - 33'(org);

  always_ff @(posedge clk) begin
    if (en.sub) begin
      neg_q <= diff[32];
      mag_q <= diff[32] ? 32'(-diff) : diff[31:0];
    end
    if (en.mul) begin
      neg_mul_q <= neg_q;
      prod_q    <= mag_q * inv;
    end
  end

  // add one half, drop the 32 fraction bits
  assign sum     = {1'b0, prod_q} + 65'h0_8000_0000;
  assign rounded = sum[64:32];

  always_comb begin
    if (neg_mul_q) begin
      if (rounded > 33'd32768) begin
        idx = IDX_MIN;
      end else begin
        idx = signed'(16'(-rounded[15:0]));
      end
    end else begin
      if (rounded > 33'd32767) begin
        idx = IDX_MAX;
      end else begin
        idx = signed'(rounded[15:0]);
      end
    end
  end

endmodule

/* sv/grid_map_cell_access.sv */
// Grid map cell store: one read, write or compare of one cell per request.
//
// Channels: a request is taken at the rising edge where start is high and
// busy is low. Its one result appears on read_value, status, equal, cell_x
// and cell_y for exactly one cycle with done high; the receiver cannot stall
// it, so it must take the result in that cycle. Configuration registers are
// written through cfg_valid/cfg_ready, cfg_index, cfg_data; the user must write
// them only while idle (not enforced by the block); cfg_ready is always high.
//
// Timing: a request by world position first passes the subtract, multiply
// and round stages of the per-axis converter; a request by coordinates skips
// them. busy stays high until the cycle after done. The cell memory, one
// write port and one registered read port, sets the remaining steps:
// address, memory access, result.
//
// Reset: the configuration and control registers return to their reset
// values and a clearing pass writes zero to every cell, one cell a cycle;
// busy is high during the pass, configuration is taken.
module grid_map_cell_access import gmca_pkg::*; #(
  parameter int unsigned X_BITS    = 8,
  parameter int unsigned Y_BITS    = 8,
  parameter int unsigned CELL_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              kind,
  input  logic signed [IDX_W-1:0] coord_x,
  input  logic signed [IDX_W-1:0] coord_y,
  input  logic signed [31:0]      pos_x,
  input  logic signed [31:0]      pos_y,
  input  logic signed [31:0]      data_value,
  output logic                    done,
  output logic signed [31:0]      read_value,
  output logic                    status,
  output logic                    equal,
  output logic signed [IDX_W-1:0] cell_x,
  output logic signed [IDX_W-1:0] cell_y,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]             cfg_data
);

  localparam int unsigned AW    = X_BITS + Y_BITS;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [12:0] CAP_X = 13'(1) << X_BITS;
  localparam logic [12:0] CAP_Y = 13'(1) << Y_BITS;

  // configuration
  logic [SIZE_W-1:0]  size_x;
  logic [SIZE_W-1:0]  size_y;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic [31:0]        inv_res_x;
  logic [31:0]        inv_res_y;

  // control
  state_t        state;
  state_t        state_next;
  logic [AW-1:0] clr_addr;
  conv_en_t      conv_en;
  logic          accept;

  // request registers
  op_t                    op_q;
  logic                   world_q;
  logic signed [31:0]     pos_x_q;
  logic signed [31:0]     pos_y_q;
  logic [CELL_BITS-1:0]   data_q;
  logic signed [IDX_W-1:0] cx_q;
  logic signed [IDX_W-1:0] cy_q;
  logic                   in_range_q;
  logic [AW-1:0]          addr_q;

  logic signed [IDX_W-1:0] conv_x;
  logic signed [IDX_W-1:0] conv_y;

  logic [12:0]     ex_full;
  logic [12:0]     ey_full;
  logic [X_BITS:0] ex;
  logic            in_x;
  logic            in_y;
  logic [AW:0]     lin;

  // cell memory
  logic [CELL_BITS-1:0] mem [DEPTH];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [CELL_BITS-1:0] mem_wdata;
  logic signed [CELL_BITS-1:0] rdata;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x    <= SIZE_RESET;
      size_y    <= SIZE_RESET;
      origin_x  <= '0;
      origin_y  <= '0;
      inv_res_x <= INV_RES_RESET;
      inv_res_y <= INV_RES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIZE_X:    size_x    <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Y:    size_y    <= cfg_data[SIZE_W-1:0];
        CFG_ORIGIN_X:  origin_x  <= signed'(cfg_data);
        CFG_ORIGIN_Y:  origin_y  <= signed'(cfg_data);
        CFG_INV_RES_X: inv_res_x <= cfg_data;
        CFG_INV_RES_Y: inv_res_y <= cfg_data;
        default: ;
      endcase
    end
  end

  gmca_world_conv u_conv_x (
    .clk  (clk),
    .en   (conv_en),
    .pos  (pos_x_q),
    .org  (origin_x),
    .inv  (inv_res_x),
    .idx  (conv_x)
  );

  gmca_world_conv u_conv_y (
    .clk  (clk),
    .en   (conv_en),
    .pos  (pos_y_q),
    .org  (origin_y),
    .inv  (inv_res_y),
    .idx  (conv_y)
  );

  // sizes above the store span saturate to it
  assign ex_full = (13'(size_x) > CAP_X) ? CAP_X : 13'(size_x);
  assign ey_full = (13'(size_y) > CAP_Y) ? CAP_Y : 13'(size_y);
  assign ex      = ex_full[X_BITS:0];
  assign in_x    = !cx_q[IDX_W-1] && (16'(cx_q) < 16'(ex_full));
  assign in_y    = !cy_q[IDX_W-1] && (16'(cy_q) < 16'(ey_full));
  assign lin     = (AW + 1)'(cx_q[X_BITS-1:0]) +
                   (AW + 1)'(ex) * (AW + 1)'(cy_q[Y_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    conv_en    = '0;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = data_q;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (&clr_addr) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = (kind inside {KIND_READ_WORLD, KIND_WRITE_WORLD, KIND_CMP_WORLD})
                       ? S_SUB : S_ADDR;
        end
      end
      S_SUB: begin
        conv_en.sub = 1'b1;
        state_next  = S_MUL;
      end
      S_MUL: begin
        conv_en.mul = 1'b1;
        state_next  = S_RND;
      end
      S_RND:  state_next = S_ADDR;
      S_ADDR: state_next = S_MEM;
      S_MEM: begin
        mem_we     = (op_q == OP_WRITE) && in_range_q;
        state_next = S_OUT;
      end
      S_OUT: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      world_q <= kind inside {KIND_READ_WORLD, KIND_WRITE_WORLD, KIND_CMP_WORLD};
      case (kind)
        KIND_WRITE_COORD, KIND_WRITE_WORLD: op_q <= OP_WRITE;
        KIND_CMP_COORD, KIND_CMP_WORLD:     op_q <= OP_CMP;
        default:                            op_q <= OP_READ;
      endcase
      pos_x_q <= pos_x;
      pos_y_q <= pos_y;
      data_q  <= data_value[CELL_BITS-1:0];
      cx_q    <= coord_x;
      cy_q    <= coord_y;
    end
    if (state == S_RND && world_q) begin
      cx_q <= conv_x;
      cy_q <= conv_y;
    end
    if (state == S_ADDR) begin
      in_range_q <= in_x && in_y;
      addr_q     <= lin[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= signed'(mem[addr_q]);
  end

  assign status     = !in_range_q;
  assign read_value = (in_range_q && op_q != OP_WRITE) ? 32'(rdata) : '0;
  assign equal      = in_range_q && (op_q == OP_CMP) && (rdata == signed'(data_q));
  assign cell_x     = cx_q;
  assign cell_y     = cy_q;

endmodule

/* sv/gmca_checker.sv */
// Port-level checks of the grid map cell store, bound to its top level.
module gmca_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               status,
  input logic               equal,
  input logic signed [31:0] read_value,
  input logic signed [15:0] cell_x,
  input logic signed [15:0] cell_y
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown while idle");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not start work");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (read_value == 32'sd0 && !equal))
    else $error("out-of-range result carries data");

  a_neg_oor: assert property (@(posedge clk) disable iff (rst)
    (done && (cell_x[15] || cell_y[15])) |-> status)
    else $error("negative cell index reported in range");

endmodule

bind grid_map_cell_access gmca_checker u_gmca_checker (.*);
